// ===== src/aes_pkg.sv =====
package aes_pkg;

  localparam int NumRounds = 10;
  localparam int KeyWidth  = 64;
  localparam int BlkWidth  = 128;

  localparam logic [0:0] KindEnc = 1'b0;
  localparam logic [0:0] KindDec = 1'b1;

  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow  = 1'b1;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] bs;
    r = 8'h01;
    bs = a;
    for (int k = 0; k < 8; k++) begin
      if (k != 0) r = gmul(r, bs);
      bs = gmul(bs, bs);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
    rotl = (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = ginv(x);
    sbox_calc = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
  endfunction

  // Constant S-box tables built at elaboration
  typedef logic [7:0] sbox_tab_t [256];

  function automatic sbox_tab_t mk_sbox();
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
    return t;
  endfunction

  function automatic sbox_tab_t mk_isbox();
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) t[sbox_calc(8'(i))] = 8'(i);
    return t;
  endfunction

  localparam sbox_tab_t SBOX  = mk_sbox();
  localparam sbox_tab_t ISBOX = mk_isbox();

  // Byte i of a 128-bit word sits at bits 127-8i
  function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
    byte_at = s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic mix);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[127-8*(r+4*c) -: 8] = SBOX[byte_at(s, r + 4*((c+r)%4))];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = byte_at(o, 4*c); a1 = byte_at(o, 4*c+1);
        a2 = byte_at(o, 4*c+2); a3 = byte_at(o, 4*c+3);
        o[127-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        o[127-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        o[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        o[127-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_at(s, 4*c); a1 = byte_at(s, 4*c+1);
      a2 = byte_at(s, 4*c+2); a3 = byte_at(s, 4*c+3);
      o[127-8*(4*c)   -: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13)
                              ^ gmul(a3, 8'd9);
      o[127-8*(4*c+1) -: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11)
                              ^ gmul(a3, 8'd13);
      o[127-8*(4*c+2) -: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14)
                              ^ gmul(a3, 8'd11);
      o[127-8*(4*c+3) -: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9)
                              ^ gmul(a3, 8'd14);
    end
    return o;
  endfunction

  // Inverse shift rows and inverse sub bytes
  function automatic logic [127:0] dec_sub(input logic [127:0] s);
    logic [127:0] o;
    o = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[127-8*(r+4*((c+r)%4)) -: 8] = ISBOX[byte_at(s, r + 4*c)];
      end
    end
    return o;
  endfunction

  // One key schedule step
  function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] t, w0, w1, w2, w3;
    t = {SBOX[k[23:16]] ^ rcon, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ===== src/aes_round.sv =====
// One pipeline stage: a forward or inverse round on the data from the stage before
module aes_round import aes_pkg::*; #(
  parameter int Rnd = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         in_valid,
  input  logic         in_kind,
  input  logic [127:0] in_data,
  input  logic [127:0] key_enc,
  input  logic [127:0] key_dec,
  output logic         out_valid,
  output logic         out_kind,
  output logic [127:0] out_data
);

  logic [127:0] enc_val;
  logic [127:0] dec_val;

  // Encrypt uses round Rnd, decrypt uses the mirrored key
  always_comb begin
    enc_val = enc_round(in_data, Rnd != NumRounds) ^ key_enc;
    dec_val = dec_sub(in_data) ^ key_dec;
    if (Rnd != NumRounds) dec_val = inv_mix(dec_val);
  end

  // Hold on stall, advance otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind <= in_kind;
      out_data <= (in_kind == KindDec) ? dec_val : enc_val;
    end
  end

endmodule

// ===== src/aes128_block_cipher.sv =====
// An accepted input word passes the key add stage, then the ten round stages, to the result.
// Throughput: one word per cycle when not stalled; eleven stages (key add, ten rounds), valid bits travel along.
// Round keys sit in registers, rebuilt one schedule step per cycle after reset or a key write;
// the input is held off until that rebuild is done.
// Reset (synchronous, active high) clears the key registers to zero and all valid bits.
// Stalls on the output freeze the whole pipeline.
module aes128_block_cipher import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_high,
  output logic [63:0] result_low
);

  logic [63:0]  key_high;
  logic [63:0]  key_low;
  logic [127:0] rk [NumRounds+1];

  logic         kx_busy;
  logic [3:0]   kx_cnt;
  logic [7:0]   kx_rcon;
  logic [127:0] kx_cur;
  logic [127:0] kx_src;
  logic [127:0] kx_next;

  logic         st_valid [NumRounds+1];
  logic         st_kind  [NumRounds+1];
  logic [127:0] st_data  [NumRounds+1];
  logic         advance;

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegKeyHigh) key_high <= cfg_data;
      else key_low <= cfg_data;
    end
  end

  // Key expansion control: restart on reset or key write, one step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      kx_busy <= 1'b1;
      kx_cnt  <= 4'd1;
      kx_rcon <= 8'h01;
    end else if (cfg_we) begin
      kx_busy <= 1'b1;
      kx_cnt  <= 4'd1;
      kx_rcon <= 8'h01;
    end else if (kx_busy) begin
      kx_cnt  <= kx_cnt + 4'd1;
      kx_rcon <= xtime(kx_rcon);
      if (kx_cnt == 4'(NumRounds)) kx_busy <= 1'b0;
    end
  end

  assign kx_src  = (kx_cnt == 4'd1) ? {key_high, key_low} : kx_cur;
  assign kx_next = key_step(kx_src, kx_rcon);

  // Round key registers, filled one round per cycle
  always_ff @(posedge clk) begin
    if (kx_busy) begin
      kx_cur <= kx_next;
      if (kx_cnt == 4'd1) rk[0] <= kx_src;
      for (int g = 1; g <= NumRounds; g++) begin
        if (kx_cnt == 4'(g)) rk[g] <= kx_next;
      end
    end
  end

  assign advance  = !st_valid[NumRounds] || out_ready;
  assign in_ready = advance && !kx_busy;

  // Stage 0: initial key addition
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (advance) begin
      st_valid[0] <= in_valid && !kx_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st_kind[0] <= kind;
      st_data[0] <= {block_high, block_low} ^
                    ((kind == KindDec) ? rk[NumRounds] : rk[0]);
    end
  end

  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes_round #(.Rnd(g)) u_round (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .in_valid (st_valid[g-1]),
      .in_kind  (st_kind[g-1]),
      .in_data  (st_data[g-1]),
      .key_enc  (rk[g]),
      .key_dec  (rk[NumRounds-g]),
      .out_valid(st_valid[g]),
      .out_kind (st_kind[g]),
      .out_data (st_data[g])
    );
  end

  assign out_valid   = st_valid[NumRounds];
  assign result_high = st_data[NumRounds][127:64];
  assign result_low  = st_data[NumRounds][63:0];

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_high) && $stable(result_low))
    else $error("result changed under stall");

  // With keys ready and no result waiting, the input is open
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !kx_busy |-> in_ready)
    else $error("input blocked with empty output");

  a_out: assert property (@(posedge clk) disable iff (rst)
    $past(st_valid[NumRounds-1]) && $past(advance) |-> out_valid)
    else $error("word lost in last stage");

endmodule

// ===== tb/tb_aes128_block_cipher.sv =====
`timescale 1ns / 100ps

module tb_aes128_block_cipher;
  import aes_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] result_high;
  logic [63:0] result_low;

  aes128_block_cipher i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .block_high(block_high), .block_low(block_low),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_high(result_high), .result_low(result_low)
  );

  typedef struct {
    logic [0:0]  op;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        known;
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } vec_t;

  typedef logic [7:0] bytes_t [16];

  localparam int CycleLimit = 2000000;
  localparam int NumRandom  = 1300;

  // predictor state: key and expanded round keys
  logic [63:0]  cur_key_hi, cur_key_lo;
  logic [127:0] round_keys [11];
  logic [7:0]   fwd_sub [256];
  logic [7:0]   inv_sub [256];

  logic [63:0] cipher_hi_q [$];
  logic [63:0] cipher_lo_q [$];
  logic [63:0] known_hi_q [$];
  logic [63:0] known_lo_q [$];
  logic        known_q [$];

  int  mismatches = 0;
  int  cycles = 0;
  bit  hold_off = 0;
  bit  feeding_done = 0;

  function automatic logic [7:0] gf_dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= a;
      a = gf_dbl(a);
    end
    return p;
  endfunction

  // build substitution tables by brute-force inverse search
  task automatic build_tables();
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 0;
      for (int y = 1; y < 256; y++)
        if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sub[x] = b;
      inv_sub[b] = 8'(x);
    end
  endtask

  task automatic expand_keys();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    {w[0], w[1], w[2], w[3]} = {cur_key_hi, cur_key_lo};
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {fwd_sub[t[23:16]] ^ rc, fwd_sub[t[15:8]], fwd_sub[t[7:0]], fwd_sub[t[31:24]]};
        rc = gf_dbl(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic bytes_t to_bytes(logic [127:0] v);
    bytes_t b;
    for (int i = 0; i < 16; i++) b[i] = v[127-8*i -: 8];
    return b;
  endfunction

  function automatic logic [127:0] from_bytes(bytes_t b);
    logic [127:0] v;
    for (int i = 0; i < 16; i++) v[127-8*i -: 8] = b[i];
    return v;
  endfunction

  function automatic logic [127:0] aes_transform(logic [0:0] op, logic [127:0] blk);
    bytes_t s, o;
    logic [7:0] a [4];
    logic [7:0] m [4];
    logic [127:0] st;
    bit dec;
    dec = (op == KindDec);
    if (dec) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    st = blk ^ round_keys[dec ? 10 : 0];
    for (int n = 1; n <= 10; n++) begin
      s = to_bytes(st);
      // shift rows and substitute
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          if (dec) o[r + 4*((c+r)%4)] = inv_sub[s[r + 4*c]];
          else o[r + 4*c] = fwd_sub[s[r + 4*((c+r)%4)]];
        end
      st = from_bytes(o);
      // inverse cipher adds the key before mixing
      if (dec) st = st ^ round_keys[10 - n];
      // mix columns on all but the last round
      if (n < 10) begin
        s = to_bytes(st);
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
          for (int r = 0; r < 4; r++) begin
            s[4*c+r] = 0;
            for (int k = 0; k < 4; k++) s[4*c+r] ^= gf_mul(a[k], m[(k+4-r)%4]);
          end
        end
        st = from_bytes(s);
      end
      // forward cipher adds the key after mixing
      if (!dec) st = st ^ round_keys[n];
    end
    return st;
  endfunction

  // clock
  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic idle_cycles();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(logic [0:0] op, logic [63:0] hi, logic [63:0] lo,
                           logic known, logic [63:0] ehi, logic [63:0] elo);
    logic [127:0] exp_v;
    in_valid <= 1'b1;
    kind <= op;
    block_high <= hi;
    block_low <= lo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_v = aes_transform(op, {hi, lo});
    cipher_hi_q.push_back(exp_v[127:64]);
    cipher_lo_q.push_back(exp_v[63:0]);
    known_q.push_back(known);
    known_hi_q.push_back(ehi);
    known_lo_q.push_back(elo);
  endtask

  task automatic write_key(logic [0:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == RegKeyHigh) cur_key_hi = val;
    else cur_key_lo = val;
    expand_keys();
  endtask

  // wait until every expected word is back, then let the pipe drain
  task automatic drain();
    in_valid <= 1'b0;
    while (cipher_hi_q.size() != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // result checker
  always @(posedge clk) begin
    logic [63:0] ehi, elo;
    if (!rst && out_valid && out_ready) begin
      if (cipher_hi_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h_%h", result_high, result_low);
      end else begin
        ehi = cipher_hi_q.pop_front();
        elo = cipher_lo_q.pop_front();
        if (known_q.pop_front()) begin
          ehi = known_hi_q[0];
          elo = known_lo_q[0];
        end
        void'(known_hi_q.pop_front());
        void'(known_lo_q.pop_front());
        if (result_high !== ehi || result_low !== elo) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h_%h got %h_%h", ehi, elo, result_high, result_low);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      if (!feeding_done && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 2);
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    vec_t dir [$];
    logic [63:0] khi, klo;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = RegKeyHigh;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = KindEnc;
    block_high = '0;
    block_low = '0;
    build_tables();
    cur_key_hi = '0;
    cur_key_lo = '0;
    expand_keys();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset the key is all zero: known answer for zero block
    dir.push_back('{KindEnc, 64'h0, 64'h0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
    dir.push_back('{KindDec, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, 64'h0, 64'h0});
    dir.push_back('{KindEnc, '1, '1, 0, 0, 0});
    dir.push_back('{KindDec, '1, '1, 0, 0, 0});
    dir.push_back('{KindDec, 64'h0, 64'h0, 0, 0, 0});
    foreach (dir[i])
      send_word(dir[i].op, dir[i].hi, dir[i].lo, dir[i].known, dir[i].exp_hi, dir[i].exp_lo);
    drain();

    // standard key 000102..0f: known vectors
    write_key(RegKeyHigh, 64'h0001020304050607);
    write_key(RegKeyLow, 64'h08090a0b0c0d0e0f);
    dir.delete();
    dir.push_back('{KindEnc, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
                    64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a});
    dir.push_back('{KindDec, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
                    64'h0011223344556677, 64'h8899aabbccddeeff});
    dir.push_back('{KindEnc, 64'h8000000000000000, 64'h1, 0, 0, 0});
    dir.push_back('{KindDec, 64'h1, 64'h8000000000000000, 0, 0, 0});
    foreach (dir[i])
      send_word(dir[i].op, dir[i].hi, dir[i].lo, dir[i].known, dir[i].exp_hi, dir[i].exp_lo);
    drain();

    // all-ones key, then back-to-back words under a long output hold-off
    write_key(RegKeyHigh, '1);
    write_key(RegKeyLow, '1);
    hold_off = 1;
    for (int i = 0; i < 30; i++) send_word(1'($urandom), rand64(), rand64(), 0, 0, 0);
    drain();

    // random key phases with random words and gaps
    for (int ph = 0; ph < 8; ph++) begin
      khi = rand64();
      klo = rand64();
      if ($urandom_range(0, 1)) write_key(RegKeyHigh, khi);
      else write_key(RegKeyLow, klo);
      write_key($urandom_range(0, 1) ? RegKeyHigh : RegKeyLow, rand64());
      for (int i = 0; i < NumRandom / 8; i++) begin
        send_word(1'($urandom), rand64(), rand64(), 0, 0, 0);
        idle_cycles();
      end
      drain();
    end

    feeding_done = 1;
    drain();
    if (mismatches == 0 && cipher_hi_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/aes_pkg.sv
src/aes_round.sv
src/aes128_block_cipher.sv
tb/tb_aes128_block_cipher.sv
